// ===== sv/assert_macros.svh =====
// Assertion macros shared by the frame bitmap modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define FBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define FBM_NEVER(lbl, cond, msg) \
  `FBM_ASSERT(lbl, !(cond), msg)

`endif

// ===== sv/fbm_pkg.sv =====
// Types, constants and helper functions of the frame bitmap block.
`default_nettype none

package fbm_pkg;

  localparam int FRAME_W    = 16;
  localparam int COUNT_W    = 17;
  localparam int WORD_BITS  = 64;
  localparam int BIT_IDX_W  = $clog2(WORD_BITS);
  localparam int MAP_AW     = FRAME_W - BIT_IDX_W;
  localparam int MAP_WORDS  = 1 << MAP_AW;
  localparam int MAX_FRAMES = MAP_WORDS * WORD_BITS;
  localparam int WCNT_W     = $clog2(MAP_WORDS + 1);
  localparam int BYTE_BITS  = 8;
  localparam int WORD_BYTES = WORD_BITS / BYTE_BITS;
  localparam int BYTE_IDX_W = $clog2(WORD_BYTES);
  localparam int BYTE_BIT_W = $clog2(BYTE_BITS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [COUNT_W-1:0]   FRAME_COUNT_RST = COUNT_W'(MAX_FRAMES);
  localparam logic [WORD_BITS-1:0] WORD_ONES       = '1;
  localparam logic [BIT_IDX_W-1:0] TOP_BIT         = BIT_IDX_W'(WORD_BITS - 1);

  typedef struct packed {
    logic [FRAME_W-1:0] range_first;
    logic [FRAME_W-1:0] range_last;
    logic               mark_free;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] lowest_free;
    logic               free_found;
  } out_item_t;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [MAP_AW-1:0]    first_word;
    logic [MAP_AW-1:0]    last_word;
    logic [BIT_IDX_W-1:0] first_bit;
    logic [BIT_IDX_W-1:0] last_bit;
    logic                 mark_free;
    logic                 skip;
  } cmd_t;

  // Index of the lowest set bit; an all-zero word gives the top index.
  function automatic logic [BIT_IDX_W-1:0] low_bit_idx(input logic [WORD_BITS-1:0] w);
    logic [WORD_BYTES-1:0] nz;
    logic [BYTE_IDX_W-1:0] byte_sel;
    logic [BYTE_BIT_W-1:0] bit_sel;
    logic [BYTE_BITS-1:0]  sel_byte;
    for (int b = 0; b < WORD_BYTES; b++) begin
      nz[b] = |w[b*BYTE_BITS +: BYTE_BITS];
    end
    byte_sel = BYTE_IDX_W'(WORD_BYTES - 1);
    for (int b = WORD_BYTES - 1; b >= 0; b--) begin
      if (nz[b]) begin
        byte_sel = BYTE_IDX_W'(b);
      end
    end
    sel_byte = w[{byte_sel, {BYTE_BIT_W{1'b0}}} +: BYTE_BITS];
    bit_sel = BYTE_BIT_W'(BYTE_BITS - 1);
    for (int i = BYTE_BITS - 1; i >= 0; i--) begin
      if (sel_byte[i]) begin
        bit_sel = BYTE_BIT_W'(i);
      end
    end
    return {byte_sel, bit_sel};
  endfunction

endpackage

`default_nettype wire

// ===== sv/fbm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fbm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/fbm_front.sv =====
// Input side: accepts range items and classifies them into word commands.
`default_nettype none

module fbm_front (
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire fbm_pkg::in_item_t in_data_i,
  input  wire logic              q_full_i,
  input  wire logic              clearing_i,
  output logic                   push_o,
  output fbm_pkg::cmd_t          cmd_o
);
  import fbm_pkg::*;

  // Hold off while the map is being cleared or the queue has no room.
  assign in_stall_o = q_full_i | clearing_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  always_comb begin
    cmd_o.first_word = in_data_i.range_first[FRAME_W-1:BIT_IDX_W];
    cmd_o.last_word  = in_data_i.range_last[FRAME_W-1:BIT_IDX_W];
    cmd_o.first_bit  = in_data_i.range_first[BIT_IDX_W-1:0];
    cmd_o.last_bit   = in_data_i.range_last[BIT_IDX_W-1:0];
    cmd_o.mark_free  = in_data_i.mark_free;
    // A reversed range leaves the map alone but still gets a search.
    cmd_o.skip       = in_data_i.range_first > in_data_i.range_last;
  end

endmodule

`default_nettype wire

// ===== sv/fbm_queue.sv =====
// Short command queue between the front and the back.
`default_nettype none
`include "assert_macros.svh"

module fbm_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire fbm_pkg::cmd_t push_cmd_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               head_valid_o,
  output fbm_pkg::cmd_t      head_cmd_o
);
  import fbm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o       = count_q == CNT_W'(QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_next(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_next(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  `FBM_NEVER(q_no_overflow, push_i && full_o && !pop_i, "command queue overflow")
  `FBM_NEVER(q_no_underflow, pop_i && !head_valid_o, "pop from empty command queue")

endmodule

`default_nettype wire

// ===== sv/fbm_back.sv =====
// Execution side: clears the map, marks word ranges, scans for the lowest free frame.
`default_nettype none
`include "assert_macros.svh"

module fbm_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [fbm_pkg::COUNT_W-1:0] frame_count_i,
  input  wire logic                        q_valid_i,
  input  wire fbm_pkg::cmd_t               q_cmd_i,
  output logic                             q_pop_o,
  output logic                             clearing_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output fbm_pkg::out_item_t               out_data_o
);
  import fbm_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_MARK  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_ENC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [MAP_AW-1:0]    clr_cnt_q, clr_cnt_d;
  cmd_t                 cmd_q, cmd_d;
  logic [MAP_AW-1:0]    cur_q, cur_d;
  logic [WCNT_W-1:0]    iss_q, iss_d;
  logic                 pend_q, pend_d;
  logic [MAP_AW-1:0]    pend_idx_q, pend_idx_d;
  logic [MAP_AW-1:0]    hit_idx_q, hit_idx_d;
  logic [WORD_BITS-1:0] hit_word_q, hit_word_d;
  out_item_t            res_q, res_d;
  logic                 out_valid_q, out_valid_d;
  out_item_t            out_data_q;
  logic                 load;
  logic                 mark_in_range;

  logic                 ram_we, ram_re;
  logic [MAP_AW-1:0]    ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  logic [COUNT_W:0]           rounded;
  logic [COUNT_W-BIT_IDX_W:0] words_wide;
  logic [WCNT_W-1:0]          scan_words;
  logic [BIT_IDX_W-1:0]       lo, hi;
  logic [WORD_BITS-1:0]       mask, merged;

  fbm_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Words to search: frame count rounded up to whole words, limited to the map.
  always_comb begin
    rounded    = {1'b0, frame_count_i} + (COUNT_W + 1)'(WORD_BITS - 1);
    words_wide = rounded[COUNT_W:BIT_IDX_W];
    scan_words = (words_wide > (COUNT_W - BIT_IDX_W + 1)'(MAP_WORDS))
                 ? WCNT_W'(MAP_WORDS) : words_wide[WCNT_W-1:0];
  end

  // Edge words take the range's bit offsets, inner words are covered in full.
  always_comb begin
    lo     = (cur_q == cmd_q.first_word) ? cmd_q.first_bit : '0;
    hi     = (cur_q == cmd_q.last_word) ? cmd_q.last_bit : TOP_BIT;
    mask   = (WORD_ONES >> (TOP_BIT - hi)) & (WORD_ONES << lo);
    merged = cmd_q.mark_free ? (ram_rdata | mask) : (ram_rdata & ~mask);
  end

  always_comb begin
    state_d    = state_q;
    clr_cnt_d  = clr_cnt_q;
    cmd_d      = cmd_q;
    cur_d      = cur_q;
    iss_d      = iss_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    hit_idx_d  = hit_idx_q;
    hit_word_d = hit_word_q;
    res_d      = res_q;
    load       = 1'b0;
    q_pop_o    = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = cur_q;
    ram_wdata  = merged;
    ram_re     = 1'b0;
    ram_raddr  = cur_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + MAP_AW'(1);
        if (clr_cnt_q == MAP_AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          iss_d   = '0;
          pend_d  = 1'b0;
          if (q_cmd_i.skip) begin
            state_d = S_SCAN;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = q_cmd_i.first_word;
            cur_d     = q_cmd_i.first_word;
            state_d   = S_MARK;
          end
        end
      end
      S_MARK: begin
        // Write back this word while fetching the next one.
        ram_we = 1'b1;
        if (cur_q == cmd_q.last_word) begin
          state_d = S_SCAN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = cur_q + MAP_AW'(1);
          cur_d     = cur_q + MAP_AW'(1);
        end
      end
      S_SCAN: begin
        priority if (pend_q && (ram_rdata != '0)) begin
          hit_word_d = ram_rdata;
          hit_idx_d  = pend_idx_q;
          state_d    = S_ENC;
        end else if (iss_q < scan_words) begin
          ram_re     = 1'b1;
          ram_raddr  = iss_q[MAP_AW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = iss_q[MAP_AW-1:0];
          iss_d      = iss_q + WCNT_W'(1);
        end else begin
          res_d.lowest_free = '0;
          res_d.free_found  = 1'b0;
          state_d           = S_DONE;
        end
      end
      S_ENC: begin
        res_d.lowest_free = {hit_idx_q, low_bit_idx(hit_word_q)};
        res_d.free_found  = 1'b1;
        state_d           = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      iss_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      iss_q       <= iss_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    cur_q      <= cur_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_word_q <= hit_word_d;
    res_q      <= res_d;
    if (load) begin
      out_data_q <= res_q;
    end
  end

  assign clearing_o  = state_q == S_CLEAR;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign mark_in_range = (cur_q >= cmd_q.first_word) && (cur_q <= cmd_q.last_word);

  `FBM_NEVER(bk_clear_no_read, (state_q == S_CLEAR) && ram_re, "map read during clearing pass")
  `FBM_ASSERT(bk_enc_nonzero, (state_q == S_ENC) |-> (hit_word_q != '0), "encoding a zero word")
  `FBM_ASSERT(bk_mark_in_range, (state_q == S_MARK) |-> mark_in_range, "mark outside range")

endmodule

`default_nettype wire

// ===== sv/frame_bitmap_range_mark_find_free.sv =====
// Top level of the frame bitmap: range mark and lowest-free search.
//
// Keeps a map of 65536 frames in 1024 words of 64 bits; a set bit is a free frame.
// Input channel (in_valid_i / in_stall_o / in_data_i) carries an inclusive frame
// range and a free-or-used mark; a transfer happens when valid is high and stall low.
// Each item produces one result on the output channel (out_valid_o / out_stall_i /
// out_data_o): the lowest free frame after the update and a found flag.
// An item has M words marked at one word per cycle, then S words scanned at one
// per cycle through the single map read port, where S stops at the first non-zero
// word or at ceil(frame_count/64), limited to the 1024 words of the map; items run
// one at a time through the map.
// A two-entry queue keeps taking items while one is worked on, and a finished
// result waits in the output register while the receiver stalls.
// After reset a pass over all 1024 words clears the map (all frames used) while the
// input stalls. frame_count resets to 65536 and is written through cfg_we_i /
// cfg_wdata_i only while the block is idle: a rule for the user, not enforced.
`default_nettype none

module frame_bitmap_range_mark_find_free (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire fbm_pkg::in_item_t           in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output fbm_pkg::out_item_t               out_data_o,
  input  wire logic                        cfg_we_i,
  input  wire logic [fbm_pkg::COUNT_W-1:0] cfg_wdata_i
);
  import fbm_pkg::*;

  logic [COUNT_W-1:0] frame_count_q;
  logic               q_full, q_push, q_pop, q_valid, clearing;
  cmd_t               push_cmd, head_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  fbm_front u_front (
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .clearing_i(clearing),
    .push_o    (q_push),
    .cmd_o     (push_cmd)
  );

  fbm_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_cmd_i  (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_valid_o(q_valid),
    .head_cmd_o  (head_cmd)
  );

  fbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_count_i(frame_count_q),
    .q_valid_i    (q_valid),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

`default_nettype wire

// ===== verif/frame_bitmap_range_mark_find_free_tb.sv =====
// Self-checking testbench for the frame bitmap range mark and lowest-free search block.
module frame_bitmap_range_mark_find_free_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fbm_pkg::*;

  localparam int   CLK_PERIOD  = 10;
  localparam logic MARK_USED   = 1'b0;
  localparam logic MARK_FREE   = 1'b1;
  localparam int   REPORT_MAX  = 10;
  localparam int   PHASE_ITEMS = 29;
  localparam int   IDLE_PCT    = 23;
  localparam int   FRAME_TOP   = (1 << FRAME_W) - 1;
  localparam int   COUNT_TOP   = (1 << COUNT_W) - 1;

  localparam logic [COUNT_W-1:0] PHASE_COUNTS [8] = '{
    17'd0, 17'd1, 17'd64, 17'd65, 17'h1FFFF, 17'd65535, 17'd1000, 17'd65536
  };

  localparam in_item_t DIRECTED [16] = '{
    '{16'd5,     16'd4,     MARK_FREE},
    '{16'd0,     16'd0,     MARK_FREE},
    '{16'd0,     16'd0,     MARK_USED},
    '{16'd65535, 16'd65535, MARK_FREE},
    '{16'd63,    16'd64,    MARK_FREE},
    '{16'd0,     16'd65535, MARK_USED},
    '{16'd0,     16'd65535, MARK_FREE},
    '{16'd0,     16'd65534, MARK_USED},
    '{16'd65535, 16'd0,     MARK_USED},
    '{16'd100,   16'd100,   MARK_FREE},
    '{16'd64,    16'd127,   MARK_USED},
    '{16'd128,   16'd191,   MARK_FREE},
    '{16'd128,   16'd129,   MARK_USED},
    '{16'd65472, 16'd65535, MARK_USED},
    '{16'd1,     16'd62,    MARK_FREE},
    '{16'd0,     16'd65535, MARK_USED}
  };

  class frame_map_scoreboard;
    logic [WORD_BITS-1:0] map_words [MAP_WORDS];
    logic [COUNT_W-1:0]   frame_count;
    out_item_t            expected_q[$];
    int                   errors;

    function new();
      foreach (map_words[i]) map_words[i] = '0;
      frame_count = FRAME_COUNT_RST;
      errors      = 0;
    endfunction

    // The last searched word is looked at in full, tail bits included.
    function out_item_t search_map();
      out_item_t res;
      int        nwords;
      res    = '0;
      nwords = (int'(frame_count) + WORD_BITS - 1) / WORD_BITS;
      if (nwords > MAP_WORDS) nwords = MAP_WORDS;
      for (int w = 0; w < nwords; w++) begin
        if (map_words[w] != '0) begin
          for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (map_words[w][b]) res.lowest_free = FRAME_W'(w * WORD_BITS + b);
          end
          res.free_found = 1'b1;
          return res;
        end
      end
      return res;
    endfunction

    function void note_transfer(in_item_t item);
      int                   fw, lw, lo, hi;
      logic [WORD_BITS-1:0] mask;
      fw = int'(item.range_first) >> BIT_IDX_W;
      lw = int'(item.range_last) >> BIT_IDX_W;
      // A reversed range leaves the map alone, but the search still reports.
      if (item.range_first <= item.range_last) begin
        for (int w = fw; w <= lw; w++) begin
          lo   = (w == fw) ? int'(item.range_first) % WORD_BITS : 0;
          hi   = (w == lw) ? int'(item.range_last) % WORD_BITS : WORD_BITS - 1;
          mask = (WORD_ONES >> (WORD_BITS - 1 - hi)) & (WORD_ONES << lo);
          if (item.mark_free == MARK_FREE) map_words[w] |= mask;
          else map_words[w] &= ~mask;
        end
      end
      expected_q.push_back(search_map());
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: lowest_free=%0d free_found=%0b",
                   got.lowest_free, got.free_found);
      end else begin
        want = expected_q.pop_front();
        if (got.lowest_free !== want.lowest_free || got.free_found !== want.free_found) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("mismatch: expected lowest_free=%0d free_found=%0b, got lowest_free=%0d free_found=%0b",
                     want.lowest_free, want.free_found, got.lowest_free, got.free_found);
        end
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;
  bit                  quiet     = 1'b0;
  frame_map_scoreboard sb        = new();

  frame_bitmap_range_mark_find_free dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic send_item(input in_item_t item);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    // Hold the payload until the transfer.
    do @(posedge clk); while (in_stall);
    sb.note_transfer(in_data);
  endtask

  task automatic write_frame_count(input logic [COUNT_W-1:0] value);
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we         <= 1'b0;
    sb.frame_count  = value;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i]);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph > 0 && ph < 9) write_frame_count(PHASE_COUNTS[ph - 1]);
      if (ph == 9) write_frame_count(COUNT_W'($urandom_range(COUNT_TOP)));
      quiet <= (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        int        kind, first, span, last;
        logic      mark;
        out_item_t lowest;
        lowest = sb.search_map();
        kind   = $urandom_range(9);
        first  = $urandom_range(FRAME_TOP);
        span   = $urandom_range(150);
        mark   = $urandom_range(1);
        case (kind)
          0, 1, 2: begin
            // Use up the lowest free frames to push the search further out.
            if (lowest.free_found) first = lowest.lowest_free;
            mark = MARK_USED;
            span = $urandom_range(300);
          end
          3, 4: mark = MARK_FREE;
          5: first = $urandom_range(2047);
          6: begin
            first = $urandom_range(MAP_WORDS - 1) * WORD_BITS;
            span  = WORD_BITS * $urandom_range(1, 4) - 1;
          end
          9: begin
            first = $urandom_range(MAP_WORDS - 1) * WORD_BITS
                    + ($urandom_range(1) ? WORD_BITS - 1 : 0);
            span  = 0;
          end
          default: ;
        endcase
        last = (first + span > FRAME_TOP) ? FRAME_TOP : first + span;
        if (kind == 7) last = $urandom_range(FRAME_TOP);
        if (kind == 8) begin
          first = $urandom_range(1, FRAME_TOP);
          last  = $urandom_range(first - 1);
        end
        send_item(in_item_t'{FRAME_W'(first), FRAME_W'(last), mark});
      end
    end

    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (2100) @(posedge clk);
    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  // Give up well beyond the slowest correct run.
  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/fbm_pkg.sv
sv/fbm_ram.sv
sv/fbm_front.sv
sv/fbm_queue.sv
sv/fbm_back.sv
sv/frame_bitmap_range_mark_find_free.sv
verif/frame_bitmap_range_mark_find_free_tb.sv
